// File: hw/rtl/dfr_pkg.sv
// shared constants and types for the header checked packet deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

  localparam int HDR_BYTES   = 10;
  localparam int WIN_DEPTH   = HDR_BYTES - 1;
  localparam int FILL_BITS   = $clog2(WIN_DEPTH + 1);
  localparam int LENGTH_BITS = 32;

  localparam logic [31:0] LEN_MASK = 32'hFFFF_FFFF >> (32 - LENGTH_BITS);

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic                   ok;
    logic                   zero_len;
    logic [LENGTH_BITS-1:0] len;
  } hdr_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/header_checked_packet_deframer.sv
// a byte's result passes through the input register and then the result register
// throughput: one byte per cycle while out_ready holds, set by the single header test between
// input and result registers; the input register, if empty, refills while a result waits
// reset: synchronous active high rst clears control, fill count, length and start word
`timescale 1ns / 1ps
`default_nettype none

module header_checked_packet_deframer import dfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        rx_valid,
  output logic             rx_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       payload_byte,
  output logic             last_of_packet,
  output logic             empty_packet
);

  logic [31:0]            start_word;
  logic                   s1_valid;
  byte_t                  s1_byte;
  byte_t                  window [WIN_DEPTH];
  logic [FILL_BITS-1:0]   window_fill;
  logic                   in_payload;
  logic [LENGTH_BITS-1:0] bytes_remaining;
  hdr_result_t            hdr;
  logic                   out_free;
  logic                   proc;
  logic                   win_full;
  logic                   emit;

  dfr_hdr_check u_check (
    .window     (window),
    .newest     (s1_byte),
    .start_word (start_word),
    .result     (hdr)
  );

  assign out_free = !out_valid || out_ready;
  assign proc     = s1_valid && out_free;
  assign rx_ready = !s1_valid || proc;
  assign win_full = window_fill == FILL_BITS'(WIN_DEPTH);
  assign emit     = in_payload || (win_full && hdr.ok && hdr.zero_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_word <= '0;
    end else if (cfg_we) begin
      start_word <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_ready) begin
      s1_valid <= rx_valid;
    end
    if (rx_ready && rx_valid) begin
      s1_byte <= rx_byte;
    end
  end

  // hunt window, newest byte at the top
  always_ff @(posedge clk) begin
    if (proc && !in_payload) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[WIN_DEPTH-1] <= s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill     <= '0;
      in_payload      <= 1'b0;
      bytes_remaining <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (proc) begin
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (proc) begin
        if (in_payload) begin
          bytes_remaining <= bytes_remaining - 1'b1;
          if (bytes_remaining == LENGTH_BITS'(1)) begin
            in_payload <= 1'b0;
          end
        end else if (!win_full) begin
          window_fill <= window_fill + 1'b1;
        end else if (hdr.ok) begin
          window_fill <= '0;
          if (!hdr.zero_len) begin
            in_payload      <= 1'b1;
            bytes_remaining <= hdr.len;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (proc) begin
      if (in_payload) begin
        payload_byte   <= s1_byte;
        last_of_packet <= bytes_remaining == LENGTH_BITS'(1);
        empty_packet   <= 1'b0;
      end else begin
        payload_byte   <= '0;
        last_of_packet <= 1'b1;
        empty_packet   <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dfr_hdr_check.sv
// header test on a ten byte candidate: start word, length range, checksum
// depends on dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfr_hdr_check import dfr_pkg::*; (
  input  wire byte_t       window [WIN_DEPTH],
  input  wire byte_t       newest,
  input  wire logic [31:0] start_word,
  output hdr_result_t      result
);

  logic [31:0] cand_start;
  logic [31:0] cand_len;
  logic [15:0] cand_csum;
  logic [17:0] sum_all;
  logic [16:0] folded;
  logic [15:0] expect_csum;
  logic        len_fits;

  always_comb begin
    cand_start  = {window[3], window[2], window[1], window[0]};
    cand_len    = {window[7], window[6], window[5], window[4]};
    cand_csum   = {newest, window[8]};
    sum_all     = 18'(start_word[15:0]) + 18'(start_word[31:16])
                + 18'(cand_len[15:0]) + 18'(cand_len[31:16]);
    folded      = 17'(sum_all[15:0]) + 17'(sum_all[17:16]);
    expect_csum = ~folded[15:0];
    len_fits    = (cand_len & ~LEN_MASK) == 32'd0;

    result.ok       = (cand_start == start_word) && (cand_csum == expect_csum) && len_fits;
    result.zero_len = cand_len == 32'd0;
    result.len      = cand_len[LENGTH_BITS-1:0];
  end

endmodule

`default_nettype wire
